FILE: design/pphc_pkg.sv
// ----------------------------------------------------------------------------
// pphc_pkg
// Shared types, widths and constants of the PID position hold controller.
// ----------------------------------------------------------------------------
package pphc_pkg;

    localparam int STILL_TIME_MS      = 50;
    localparam int INTEGRAL_BOUND     = 50000;
    localparam int GAIN_FRACTION_BITS = 8;

    localparam int POS_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 34;
    localparam int DER_W   = 35;
    localparam int INT_W   = 17;
    localparam int DRV_W   = 9;
    localparam int PERR_W  = GAIN_W + ERR_W;
    localparam int PDER_W  = GAIN_W + DER_W;
    localparam int PINT_W  = GAIN_W + INT_W;
    localparam int SUM_W   = PDER_W + 2;
    localparam int QUOT_W  = SUM_W - GAIN_FRACTION_BITS;

    localparam int unsigned DEFAULT_DEADBAND = 3;
    localparam int unsigned RELEASE_MARGIN   = 10;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_GAIN_P          = 3'd0,
        REG_GAIN_I          = 3'd1,
        REG_GAIN_D          = 3'd2,
        REG_HOLD_DRIVE      = 3'd3,
        REG_HOLD_DELAY_MS   = 3'd4,
        REG_ERROR_DEADBAND  = 3'd5,
        REG_BACKLASH_COUNTS = 3'd6,
        REG_DRIVE_LIMIT     = 3'd7
    } t_reg_index;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b10
    } t_dir;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [7:0]               hold_drive;
        logic [15:0]              hold_delay_ms;
        logic [15:0]              error_deadband;
        logic [15:0]              backlash_counts;
        logic [7:0]               drive_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] target_position;
        logic signed [POS_W-1:0] encoder_position;
        logic [POS_W-1:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [DER_W-1:0] deriv;
        logic signed [INT_W-1:0] integ;
        logic                    hold_override;
        logic signed [DRV_W-1:0] hold_val;
        logic                    settled;
        logic                    holding;
    } t_ctl;

    typedef struct packed {
        logic signed [PERR_W-1:0] p_err;
        logic signed [PDER_W-1:0] p_der;
        logic signed [PINT_W-1:0] p_int;
        logic                     hold_override;
        logic signed [DRV_W-1:0]  hold_val;
        logic                     settled;
        logic                     holding;
    } t_prod;

endpackage

FILE: design/pphc_state.sv
// ----------------------------------------------------------------------------
// pphc_state
// Controller state: backlash, error, integral and settle/hold decisions.
// ----------------------------------------------------------------------------
module pphc_state (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pphc_pkg::t_cfg     i_cfg,
    input  pphc_pkg::t_in_item i_item,
    input  logic               i_item_valid,
    input  logic               i_advance,
    output pphc_pkg::t_ctl     o_ctl,
    output logic               o_ctl_valid
);

    logic signed [pphc_pkg::POS_W-1:0] r_prev_target;
    logic signed [pphc_pkg::ERR_W-1:0] r_prev_err;
    logic signed [pphc_pkg::INT_W-1:0] r_integ;
    pphc_pkg::t_dir                    r_prev_dir;
    logic [pphc_pkg::POS_W-1:0]        r_still_start;
    logic                              r_still_valid;
    logic                              r_is_still;
    logic                              r_settled;
    logic                              r_holding;
    logic [pphc_pkg::POS_W-1:0]        r_deadline;
    pphc_pkg::t_ctl                    r_ctl;
    logic                              r_ctl_valid;

    logic signed [pphc_pkg::INT_W-1:0] n_integ;
    logic [pphc_pkg::POS_W-1:0]        n_still_start;
    logic                              n_still_valid;
    logic                              n_is_still;
    logic                              n_settled;
    logic                              n_holding;
    logic [pphc_pkg::POS_W-1:0]        n_deadline;
    pphc_pkg::t_dir                    n_dir;
    pphc_pkg::t_ctl                    n_ctl;

    logic                              commit;
    logic                              moved;
    logic signed [pphc_pkg::ERR_W-1:0] eff;
    logic signed [pphc_pkg::ERR_W-1:0] err;
    logic signed [pphc_pkg::DER_W-1:0] int_raw;
    logic signed [pphc_pkg::INT_W-1:0] int_base;
    logic signed [pphc_pkg::INT_W-1:0] int_clamped;
    logic [pphc_pkg::ERR_W-1:0]        aerr;
    logic [16:0]                       band;
    logic [16:0]                       release_lvl;
    logic [pphc_pkg::POS_W-1:0]        still_from;
    logic [pphc_pkg::POS_W-1:0]        hold_gap;
    logic                              hold_ready;
    logic signed [pphc_pkg::DRV_W-1:0] hold_mag;

    assign commit = i_item_valid && i_advance;

    always_comb begin
        moved = (i_item.target_position != r_prev_target);
        if (i_item.target_position > r_prev_target) begin
            n_dir = pphc_pkg::DIR_POS;
        end else if (moved) begin
            n_dir = pphc_pkg::DIR_NEG;
        end else begin
            n_dir = pphc_pkg::DIR_NONE;
        end

        // Still timer: restarts on any target motion.
        n_still_start = r_still_start;
        n_still_valid = r_still_valid;
        n_is_still    = 1'b0;
        n_settled     = r_settled;
        n_holding     = r_holding;
        n_deadline    = r_deadline;
        still_from    = r_still_valid ? r_still_start : i_item.now_ms;
        if (moved) begin
            n_still_valid = 1'b0;
            n_settled     = 1'b0;
            n_holding     = 1'b0;
        end else begin
            n_still_start = still_from;
            n_still_valid = 1'b1;
            n_is_still    = ((i_item.now_ms - still_from) >=
                             pphc_pkg::POS_W'(pphc_pkg::STILL_TIME_MS));
        end

        // Backlash is added only on a true reversal of direction.
        eff = pphc_pkg::ERR_W'(i_item.target_position);
        if (n_dir != pphc_pkg::DIR_NONE && r_prev_dir != pphc_pkg::DIR_NONE &&
            n_dir != r_prev_dir && i_cfg.backlash_counts != 16'd0) begin
            if (n_dir == pphc_pkg::DIR_POS) begin
                eff = eff + $signed({18'd0, i_cfg.backlash_counts});
            end else begin
                eff = eff - $signed({18'd0, i_cfg.backlash_counts});
            end
        end
        err = eff - pphc_pkg::ERR_W'(i_item.encoder_position);

        if ((err > 0 && r_prev_err < 0) || (err < 0 && r_prev_err > 0)) begin
            int_base = '0;
        end else begin
            int_base = r_integ;
        end
        int_raw = pphc_pkg::DER_W'(int_base) + pphc_pkg::DER_W'(err);
        if (int_raw > pphc_pkg::DER_W'(pphc_pkg::INTEGRAL_BOUND)) begin
            int_clamped = pphc_pkg::INT_W'(pphc_pkg::INTEGRAL_BOUND);
        end else if (int_raw < -pphc_pkg::DER_W'(pphc_pkg::INTEGRAL_BOUND)) begin
            int_clamped = -pphc_pkg::INT_W'(pphc_pkg::INTEGRAL_BOUND);
        end else begin
            int_clamped = int_raw[pphc_pkg::INT_W-1:0];
        end
        n_integ = int_clamped;

        aerr = (err < 0) ? pphc_pkg::ERR_W'(-err) : pphc_pkg::ERR_W'(err);
        if (i_cfg.error_deadband == 16'd0) begin
            band        = 17'(pphc_pkg::DEFAULT_DEADBAND);
            release_lvl = 17'(pphc_pkg::RELEASE_MARGIN);
        end else begin
            band        = {1'b0, i_cfg.error_deadband};
            release_lvl = {1'b0, i_cfg.error_deadband} +
                          17'(pphc_pkg::RELEASE_MARGIN);
        end

        hold_mag = $signed({1'b0, i_cfg.hold_drive});
        n_ctl.hold_override = 1'b0;
        n_ctl.hold_val      = '0;
        hold_gap            = '0;
        hold_ready          = 1'b0;
        if (aerr <= pphc_pkg::ERR_W'(band) && n_is_still) begin
            n_integ = '0;
            if (!n_settled) begin
                n_settled  = 1'b1;
                n_holding  = 1'b1;
                n_deadline = i_item.now_ms + pphc_pkg::POS_W'(i_cfg.hold_delay_ms);
            end
            n_ctl.hold_override = 1'b1;
            hold_gap   = i_item.now_ms - n_deadline;
            hold_ready = (i_cfg.hold_delay_ms == 16'd0) || !hold_gap[pphc_pkg::POS_W-1];
            if (hold_ready) begin
                if (err > 0) begin
                    n_ctl.hold_val = hold_mag;
                end else if (err < 0) begin
                    n_ctl.hold_val = -hold_mag;
                end
            end
        end else if (n_settled && aerr >= pphc_pkg::ERR_W'(release_lvl)) begin
            n_settled = 1'b0;
            n_holding = 1'b0;
        end

        n_ctl.err     = err;
        n_ctl.deriv   = pphc_pkg::DER_W'(err) - pphc_pkg::DER_W'(r_prev_err);
        n_ctl.integ   = int_clamped;
        n_ctl.settled = n_settled;
        n_ctl.holding = n_holding;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_target <= '0;
            r_prev_err    <= '0;
            r_integ       <= '0;
            r_prev_dir    <= pphc_pkg::DIR_NONE;
            r_still_start <= '0;
            r_still_valid <= 1'b0;
            r_is_still    <= 1'b0;
            r_settled     <= 1'b0;
            r_holding     <= 1'b0;
            r_deadline    <= '0;
            r_ctl_valid   <= 1'b0;
        end else begin
            if (commit) begin
                r_prev_target <= i_item.target_position;
                r_prev_err    <= err;
                r_integ       <= n_integ;
                r_prev_dir    <= n_dir;
                r_still_start <= n_still_start;
                r_still_valid <= n_still_valid;
                r_is_still    <= n_is_still;
                r_settled     <= n_settled;
                r_holding     <= n_holding;
                r_deadline    <= n_deadline;
            end
            if (i_advance) begin
                r_ctl_valid <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_ctl <= n_ctl;
        end
    end

    assign o_ctl       = r_ctl;
    assign o_ctl_valid = r_ctl_valid;

    // The hold flag is only ever raised and dropped together with the settle flag.
    a_hold_tracks_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_holding == r_settled)
        else $error("hold flag differs from settle flag");

    a_integral_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= pphc_pkg::INT_W'(pphc_pkg::INTEGRAL_BOUND)) &&
        (r_integ >= -pphc_pkg::INT_W'(pphc_pkg::INTEGRAL_BOUND)))
        else $error("integral outside its clamp");

    // Settling needs a still target, so a settled tick never shows motion.
    a_settle_needs_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !r_settled && n_settled) |=> r_is_still)
        else $error("settled without a still target");

endmodule

FILE: design/pphc_pid.sv
// ----------------------------------------------------------------------------
// pphc_pid
// Gain products, Q45.8 sum with truncation toward zero, and drive saturation.
// ----------------------------------------------------------------------------
module pphc_pid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pphc_pkg::t_cfg                    i_cfg,
    input  pphc_pkg::t_ctl                    i_ctl,
    input  logic                              i_ctl_valid,
    input  logic                              i_adv_prod,
    input  logic                              i_adv_out,
    output logic                              o_prod_valid,
    output logic                              o_out_valid,
    output logic signed [pphc_pkg::DRV_W-1:0] o_drive,
    output logic                              o_settled,
    output logic                              o_holding
);

    localparam logic signed [pphc_pkg::SUM_W-1:0] TRUNC_BIAS =
        pphc_pkg::SUM_W'((1 << pphc_pkg::GAIN_FRACTION_BITS) - 1);

    pphc_pkg::t_prod                    r_prod;
    logic                               r_prod_valid;
    logic signed [pphc_pkg::DRV_W-1:0]  r_drive;
    logic                               r_settled;
    logic                               r_holding;
    logic                               r_out_valid;

    pphc_pkg::t_prod                    n_prod;
    logic signed [pphc_pkg::DRV_W-1:0]  n_drive;

    logic signed [pphc_pkg::SUM_W-1:0]  sum;
    logic signed [pphc_pkg::SUM_W-1:0]  biased;
    logic signed [pphc_pkg::QUOT_W-1:0] quot;
    logic signed [pphc_pkg::QUOT_W-1:0] pick;
    logic signed [pphc_pkg::QUOT_W-1:0] lim;

    always_comb begin
        n_prod.p_err = $signed(pphc_pkg::PERR_W'(i_cfg.gain_p)) *
                       $signed(pphc_pkg::PERR_W'(i_ctl.err));
        n_prod.p_der = $signed(pphc_pkg::PDER_W'(i_cfg.gain_d)) *
                       $signed(pphc_pkg::PDER_W'(i_ctl.deriv));
        n_prod.p_int = $signed(pphc_pkg::PINT_W'(i_cfg.gain_i)) *
                       $signed(pphc_pkg::PINT_W'(i_ctl.integ));
        n_prod.hold_override = i_ctl.hold_override;
        n_prod.hold_val      = i_ctl.hold_val;
        n_prod.settled       = i_ctl.settled;
        n_prod.holding       = i_ctl.holding;
    end

    always_comb begin
        sum = pphc_pkg::SUM_W'(r_prod.p_err) + pphc_pkg::SUM_W'(r_prod.p_der) +
              pphc_pkg::SUM_W'(r_prod.p_int);
        // Bias negative sums so the arithmetic shift truncates toward zero.
        biased = sum[pphc_pkg::SUM_W-1] ? (sum + TRUNC_BIAS) : sum;
        quot   = pphc_pkg::QUOT_W'(biased >>> pphc_pkg::GAIN_FRACTION_BITS);
        pick   = r_prod.hold_override ? pphc_pkg::QUOT_W'(r_prod.hold_val) : quot;
        lim    = $signed(pphc_pkg::QUOT_W'({1'b0, i_cfg.drive_limit}));
        if (pick > lim) begin
            n_drive = lim[pphc_pkg::DRV_W-1:0];
        end else if (pick < -lim) begin
            n_drive = pphc_pkg::DRV_W'(-lim);
        end else begin
            n_drive = pick[pphc_pkg::DRV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_adv_prod) begin
                r_prod_valid <= i_ctl_valid;
            end
            if (i_adv_out) begin
                r_out_valid <= r_prod_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_prod && i_ctl_valid) begin
            r_prod <= n_prod;
        end
        if (i_adv_out && r_prod_valid) begin
            r_drive   <= n_drive;
            r_settled <= r_prod.settled;
            r_holding <= r_prod.holding;
        end
    end

    assign o_prod_valid = r_prod_valid;
    assign o_out_valid  = r_out_valid;
    assign o_drive      = r_drive;
    assign o_settled    = r_settled;
    assign o_holding    = r_holding;

endmodule

FILE: design/pid_position_hold_controller.sv
// ----------------------------------------------------------------------------
// pid_position_hold_controller
// PID position controller with backlash compensation, settle deadband and
// hold drive, behind valid/ready item channels and an APB register port.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the four-register pipeline (input, control
// state, gain products, result) advances every cycle the result is taken.
// The controller state is updated as an item leaves the input register.
// Reset (synchronous, active low) clears all controller state and pipeline
// valid bits and loads the registers with their defaults.
module pid_position_hold_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input item channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [pphc_pkg::POS_W-1:0]   i_target_position,
    input  logic signed [pphc_pkg::POS_W-1:0]   i_encoder_position,
    input  logic [pphc_pkg::POS_W-1:0]          i_now_ms,
    // Result item channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [pphc_pkg::DRV_W-1:0]   o_drive,
    output logic                                o_settled,
    output logic                                o_holding,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pphc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pphc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pphc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    pphc_pkg::t_cfg     r_cfg;
    pphc_pkg::t_in_item r_in;
    logic               r_in_valid;

    pphc_pkg::t_ctl     ctl;
    logic               ctl_valid;
    logic               prod_valid;
    logic               out_valid;
    logic               adv_ctl;
    logic               adv_prod;
    logic               adv_out;
    logic               cfg_write;
    pphc_pkg::t_reg_index reg_idx;

    // Each stage may load whenever it is empty or the stage after it moves
    // on, so an item is taken even while a finished result is still waiting.
    assign adv_out  = !out_valid || i_ready;
    assign adv_prod = !prod_valid || adv_out;
    assign adv_ctl  = !ctl_valid || adv_prod;
    assign o_ready  = !r_in_valid || adv_ctl;
    assign o_valid  = out_valid;

    // ---------------- Register port ----------------
    // Registers sit on 32-bit words; the word index names the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = pphc_pkg::t_reg_index'(paddr[pphc_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p          <= '0;
            r_cfg.gain_i          <= '0;
            r_cfg.gain_d          <= '0;
            r_cfg.hold_drive      <= '0;
            r_cfg.hold_delay_ms   <= '0;
            r_cfg.error_deadband  <= 16'(pphc_pkg::DEFAULT_DEADBAND);
            r_cfg.backlash_counts <= '0;
            r_cfg.drive_limit     <= 8'd60;
        end else if (cfg_write) begin
            unique case (reg_idx)
                pphc_pkg::REG_GAIN_P:          r_cfg.gain_p          <= pwdata[15:0];
                pphc_pkg::REG_GAIN_I:          r_cfg.gain_i          <= pwdata[15:0];
                pphc_pkg::REG_GAIN_D:          r_cfg.gain_d          <= pwdata[15:0];
                pphc_pkg::REG_HOLD_DRIVE:      r_cfg.hold_drive      <= pwdata[7:0];
                pphc_pkg::REG_HOLD_DELAY_MS:   r_cfg.hold_delay_ms   <= pwdata[15:0];
                pphc_pkg::REG_ERROR_DEADBAND:  r_cfg.error_deadband  <= pwdata[15:0];
                pphc_pkg::REG_BACKLASH_COUNTS: r_cfg.backlash_counts <= pwdata[15:0];
                pphc_pkg::REG_DRIVE_LIMIT:     r_cfg.drive_limit     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pphc_pkg::REG_GAIN_P:          prdata = {16'd0, r_cfg.gain_p};
            pphc_pkg::REG_GAIN_I:          prdata = {16'd0, r_cfg.gain_i};
            pphc_pkg::REG_GAIN_D:          prdata = {16'd0, r_cfg.gain_d};
            pphc_pkg::REG_HOLD_DRIVE:      prdata = {24'd0, r_cfg.hold_drive};
            pphc_pkg::REG_HOLD_DELAY_MS:   prdata = {16'd0, r_cfg.hold_delay_ms};
            pphc_pkg::REG_ERROR_DEADBAND:  prdata = {16'd0, r_cfg.error_deadband};
            pphc_pkg::REG_BACKLASH_COUNTS: prdata = {16'd0, r_cfg.backlash_counts};
            pphc_pkg::REG_DRIVE_LIMIT:     prdata = {24'd0, r_cfg.drive_limit};
            default:                       prdata = '0;
        endcase
    end

    // ---------------- Input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.target_position  <= i_target_position;
            r_in.encoder_position <= i_encoder_position;
            r_in.now_ms           <= i_now_ms;
        end
    end

    // ---------------- Control state stage ----------------
    // Backlash, error, integral and the settle/hold decision for one tick;
    // the state it keeps is written as the item passes into its register.
    pphc_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (r_in),
        .i_item_valid (r_in_valid),
        .i_advance    (adv_ctl),
        .o_ctl        (ctl),
        .o_ctl_valid  (ctl_valid)
    );

    // ---------------- Gain and output stages ----------------
    // Three gain products are registered, then summed, scaled to whole
    // counts with truncation toward zero and clamped to the drive limit.
    pphc_pid u_pid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_ctl        (ctl),
        .i_ctl_valid  (ctl_valid),
        .i_adv_prod   (adv_prod),
        .i_adv_out    (adv_out),
        .o_prod_valid (prod_valid),
        .o_out_valid  (out_valid),
        .o_drive      (o_drive),
        .o_settled    (o_settled),
        .o_holding    (o_holding)
    );

    // A delivered drive never exceeds the configured limit in either direction.
    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_drive <= $signed({1'b0, r_cfg.drive_limit})) &&
                     (o_drive >= -$signed({1'b0, r_cfg.drive_limit}))))
        else $error("drive beyond the drive limit");

    // The input side only stalls when the input register holds an item.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid)
        else $error("input stalled with an empty input register");

endmodule
